[sv/world_to_screen_projection_core_assert.svh]
// Assertion macros shared by the projection core modules
`ifndef WORLD_TO_SCREEN_PROJECTION_CORE_ASSERT_SVH
`define WORLD_TO_SCREEN_PROJECTION_CORE_ASSERT_SVH

// Check a condition at every clock edge outside reset
`define W2S_ASSERT_NOW(lbl, ck, rs, cond) \
  lbl: assert property (@(posedge ck) disable iff (rs) (cond)) \
    else $error("w2s assertion failed");

// Check a consequence in the cycle after its trigger
`define W2S_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("w2s assertion failed");

`endif

[sv/w2s_pkg.sv]
// Shared types, widths and helpers for the projection core
package w2s_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 32;
  localparam int SIZE_W    = 14;
  localparam int IDX_W     = 4;
  localparam int ADDR_W    = 3;
  localparam int PROD_W    = 2 * DATA_W;
  localparam int CLIP_W    = PROD_W - FRAC_BITS + 2;
  localparam int NUM_W     = CLIP_W + 1;
  localparam int SCL_W     = NUM_W + SIZE_W;
  localparam int DIVN_W    = SCL_W + FRAC_BITS;
  localparam int QBITS     = DATA_W + 1;
  localparam int HI_W      = DIVN_W - QBITS;
  localparam int CMP_W     = (HI_W > NUM_W) ? HI_W : NUM_W;
  localparam int W_MIN     = ((1 << FRAC_BITS) + 5) / 10;
  localparam int Q_DEPTH   = 4;
  localparam int QPTR_W    = $clog2(Q_DEPTH);

  localparam logic [SIZE_W-1:0] WIDTH_RESET  = SIZE_W'(1920);
  localparam logic [SIZE_W-1:0] HEIGHT_RESET = SIZE_W'(1080);

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  localparam logic [DATA_W-1:0] SAT_POS = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] SAT_NEG = {1'b1, {(DATA_W-1){1'b0}}};

  typedef enum logic {
    CMD_LOAD    = 1'b0,
    CMD_PROJECT = 1'b1
  } cmd_t;

  typedef struct packed {
    cmd_t              kind;
    logic [IDX_W-1:0]  idx;
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
    logic [DATA_W-1:0] c;
  } q_entry_t;

  typedef struct packed {
    logic v;
    logic vis;
    logic negx;
    logic negy;
    logic ovx;
    logic ovy;
  } side_t;

  function automatic logic signed [CLIP_W-1:0] flr_ext(logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] s;
    s = p >>> FRAC_BITS;
    return s[CLIP_W-1:0];
  endfunction

  function automatic logic [DATA_W-1:0] sat(logic [QBITS-1:0] q, logic neg, logic ov);
    logic [QBITS-1:0] nq;
    nq = -q;
    if (ov) begin
      return neg ? SAT_NEG : SAT_POS;
    end else if (neg) begin
      return (q > QBITS'(SAT_NEG)) ? SAT_NEG : nq[DATA_W-1:0];
    end else begin
      return (q > QBITS'(SAT_POS)) ? SAT_POS : q[DATA_W-1:0];
    end
  endfunction

endpackage

[sv/world_to_screen_projection_core.sv]
// Top level of the world-to-screen projection core with its register port
//
// Input channel (in_valid/in_ready) carries one request per handshake.
// command = load writes coefficient coef_value at row-major coef_index
// of the 4x4 matrix and gives no result. command = project takes point
// x/y/z and gives one result on the output channel (out_valid/out_ready):
// visible, plus screen_x and screen_y in Q16.16, zero when not visible.
// Requests enter a four-entry queue; the arithmetic back end pops one per
// cycle, so throughput is one request per clock while the output is not held.
// A request passes through the queue, the matrix multiply and screen
// scaling registers, the pipelined divider (one quotient bit a stage) and
// an output register on its way to out_valid.
// When out_valid is high and the receiver holds out_ready low, the whole
// back end holds; the queue keeps taking requests until full, then in_ready drops.
// Reset clears the matrix to zero, sets width 1920 and height 1080,
// and empties the queue and pipeline. Write screen_width (address 0) and
// screen_height (address 4) only while no request is in flight.
module world_to_screen_projection_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              command,
  input  logic [w2s_pkg::IDX_W-1:0]         coef_index,
  input  logic signed [w2s_pkg::DATA_W-1:0] coef_value,
  input  logic signed [w2s_pkg::DATA_W-1:0] point_x,
  input  logic signed [w2s_pkg::DATA_W-1:0] point_y,
  input  logic signed [w2s_pkg::DATA_W-1:0] point_z,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              visible,
  output logic signed [w2s_pkg::DATA_W-1:0] screen_x,
  output logic signed [w2s_pkg::DATA_W-1:0] screen_y,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [w2s_pkg::ADDR_W-1:0]        paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  logic [w2s_pkg::SIZE_W-1:0] screen_width;
  logic [w2s_pkg::SIZE_W-1:0] screen_height;
  logic                       deq_valid;
  logic                       deq_ready;
  w2s_pkg::q_entry_t          deq_entry;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= w2s_pkg::WIDTH_RESET;
      screen_height <= w2s_pkg::HEIGHT_RESET;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[2])
        w2s_pkg::REG_WIDTH:  screen_width  <= pwdata[w2s_pkg::SIZE_W-1:0];
        w2s_pkg::REG_HEIGHT: screen_height <= pwdata[w2s_pkg::SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      w2s_pkg::REG_WIDTH:  prdata = 32'(screen_width);
      w2s_pkg::REG_HEIGHT: prdata = 32'(screen_height);
      default:             prdata = '0;
    endcase
  end

  w2s_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .command    (command),
    .coef_index (coef_index),
    .coef_value (coef_value),
    .point_x    (point_x),
    .point_y    (point_y),
    .point_z    (point_z),
    .deq_valid  (deq_valid),
    .deq_ready  (deq_ready),
    .deq_entry  (deq_entry)
  );

  w2s_back u_back (
    .clk           (clk),
    .rst           (rst),
    .deq_valid     (deq_valid),
    .deq_ready     (deq_ready),
    .deq_entry     (deq_entry),
    .screen_width  (screen_width),
    .screen_height (screen_height),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .visible       (visible),
    .screen_x      (screen_x),
    .screen_y      (screen_y)
  );

endmodule

[sv/w2s_front.sv]
// Request intake, classification and queue toward the arithmetic back end
`include "world_to_screen_projection_core_assert.svh"
module w2s_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          command,
  input  logic [w2s_pkg::IDX_W-1:0]     coef_index,
  input  logic signed [w2s_pkg::DATA_W-1:0] coef_value,
  input  logic signed [w2s_pkg::DATA_W-1:0] point_x,
  input  logic signed [w2s_pkg::DATA_W-1:0] point_y,
  input  logic signed [w2s_pkg::DATA_W-1:0] point_z,
  output logic                          deq_valid,
  input  logic                          deq_ready,
  output w2s_pkg::q_entry_t             deq_entry
);

  w2s_pkg::q_entry_t            mem [w2s_pkg::Q_DEPTH];
  w2s_pkg::q_entry_t            enq_entry;
  logic [w2s_pkg::QPTR_W-1:0]   wr_ptr;
  logic [w2s_pkg::QPTR_W-1:0]   rd_ptr;
  logic [w2s_pkg::QPTR_W:0]     count;
  logic                         push;
  logic                         pop;

  assign in_ready  = !rst && (count != (w2s_pkg::QPTR_W+1)'(w2s_pkg::Q_DEPTH));
  assign push      = in_valid && in_ready;
  assign deq_valid = (count != '0);
  assign pop       = deq_valid && deq_ready;
  assign deq_entry = mem[rd_ptr];

  always_comb begin
    enq_entry.kind = w2s_pkg::cmd_t'(command);
    enq_entry.idx  = coef_index;
    enq_entry.a    = (enq_entry.kind == w2s_pkg::CMD_PROJECT) ? point_x : coef_value;
    enq_entry.b    = point_y;
    enq_entry.c    = point_z;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= enq_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (w2s_pkg::QPTR_W+1)'(push) - (w2s_pkg::QPTR_W+1)'(pop);
    end
  end

  `W2S_ASSERT_NOW(a_count_bound, clk, rst, count <= (w2s_pkg::QPTR_W+1)'(w2s_pkg::Q_DEPTH))
  `W2S_ASSERT_NOW(a_ptr_gap, clk, rst, (wr_ptr - rd_ptr) == count[w2s_pkg::QPTR_W-1:0])
  `W2S_ASSERT_NEXT(a_count_track, clk, rst, 1'b1, count == $past(count) + (w2s_pkg::QPTR_W+1)'($past(push)) - (w2s_pkg::QPTR_W+1)'($past(pop)))

endmodule

[sv/w2s_div.sv]
// Pipelined restoring divider, one quotient bit per stage
module w2s_div (
  input  logic                        clk,
  input  logic                        en,
  input  logic [w2s_pkg::NUM_W-1:0]   rem0,
  input  logic [w2s_pkg::QBITS-1:0]   low0,
  input  logic [w2s_pkg::NUM_W-1:0]   d,
  output logic [w2s_pkg::QBITS-1:0]   q
);

  logic [w2s_pkg::NUM_W-1:0] rem_q [w2s_pkg::QBITS];
  logic [w2s_pkg::QBITS-1:0] low_q [w2s_pkg::QBITS];
  logic [w2s_pkg::NUM_W-1:0] d_q   [w2s_pkg::QBITS];
  logic [w2s_pkg::QBITS-1:0] q_q   [w2s_pkg::QBITS];

  for (genvar k = 0; k < w2s_pkg::QBITS; k++) begin : g_step
    logic [w2s_pkg::NUM_W-1:0] r_in;
    logic [w2s_pkg::NUM_W-1:0] d_in;
    logic [w2s_pkg::QBITS-1:0] l_in;
    logic [w2s_pkg::QBITS-1:0] q_in;
    logic [w2s_pkg::NUM_W:0]   trial;
    logic [w2s_pkg::NUM_W:0]   diff;

    if (k == 0) begin : g_first
      assign r_in = rem0;
      assign d_in = d;
      assign l_in = low0;
      assign q_in = '0;
    end else begin : g_next
      assign r_in = rem_q[k-1];
      assign d_in = d_q[k-1];
      assign l_in = low_q[k-1];
      assign q_in = q_q[k-1];
    end

    assign trial = {r_in, l_in[w2s_pkg::QBITS-1]};
    assign diff  = trial - {1'b0, d_in};

    always_ff @(posedge clk) begin
      if (en) begin
        if (trial >= {1'b0, d_in}) begin
          rem_q[k] <= diff[w2s_pkg::NUM_W-1:0];
          q_q[k]   <= {q_in[w2s_pkg::QBITS-2:0], 1'b1};
        end else begin
          rem_q[k] <= trial[w2s_pkg::NUM_W-1:0];
          q_q[k]   <= {q_in[w2s_pkg::QBITS-2:0], 1'b0};
        end
        low_q[k] <= {l_in[w2s_pkg::QBITS-2:0], 1'b0};
        d_q[k]   <= d_in;
      end
    end
  end

  assign q = q_q[w2s_pkg::QBITS-1];

endmodule

[sv/w2s_back.sv]
// Matrix store, clip transform, screen mapping, division and result register
`include "world_to_screen_projection_core_assert.svh"
module w2s_back (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              deq_valid,
  output logic                              deq_ready,
  input  w2s_pkg::q_entry_t                 deq_entry,
  input  logic [w2s_pkg::SIZE_W-1:0]        screen_width,
  input  logic [w2s_pkg::SIZE_W-1:0]        screen_height,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              visible,
  output logic signed [w2s_pkg::DATA_W-1:0] screen_x,
  output logic signed [w2s_pkg::DATA_W-1:0] screen_y
);

  logic                               en;
  logic                               take;
  logic [w2s_pkg::DATA_W-1:0]         mtx [16];

  logic                               s1_v;
  logic signed [w2s_pkg::PROD_W-1:0]  s1_p [9];
  logic signed [w2s_pkg::DATA_W-1:0]  s1_c [3];

  logic                               s2_v;
  logic signed [w2s_pkg::CLIP_W-1:0]  s2_cx;
  logic signed [w2s_pkg::CLIP_W-1:0]  s2_cy;
  logic signed [w2s_pkg::CLIP_W-1:0]  s2_cw;

  logic                               s3_v;
  logic                               s3_vis;
  logic signed [w2s_pkg::NUM_W-1:0]   s3_nx;
  logic signed [w2s_pkg::NUM_W-1:0]   s3_ny;
  logic signed [w2s_pkg::CLIP_W-1:0]  s3_cw;

  w2s_pkg::side_t                     s4_sd;
  logic [w2s_pkg::NUM_W-1:0]          s4_mx;
  logic [w2s_pkg::NUM_W-1:0]          s4_my;
  logic [w2s_pkg::NUM_W-1:0]          s4_d;

  w2s_pkg::side_t                     s5_sd;
  logic [w2s_pkg::SCL_W-1:0]          s5_px;
  logic [w2s_pkg::SCL_W-1:0]          s5_py;
  logic [w2s_pkg::NUM_W-1:0]          s5_d;

  logic [w2s_pkg::DIVN_W-1:0]         nx;
  logic [w2s_pkg::DIVN_W-1:0]         ny;
  logic [w2s_pkg::HI_W-1:0]           hx;
  logic [w2s_pkg::HI_W-1:0]           hy;

  w2s_pkg::side_t                     s6_sd;
  logic [w2s_pkg::NUM_W-1:0]          s6_rx;
  logic [w2s_pkg::NUM_W-1:0]          s6_ry;
  logic [w2s_pkg::QBITS-1:0]          s6_lx;
  logic [w2s_pkg::QBITS-1:0]          s6_ly;
  logic [w2s_pkg::NUM_W-1:0]          s6_d;

  w2s_pkg::side_t                     sd [w2s_pkg::QBITS];
  logic [w2s_pkg::QBITS-1:0]          qx;
  logic [w2s_pkg::QBITS-1:0]          qy;
  w2s_pkg::side_t                     last;

  assign en        = !out_valid || out_ready;
  assign deq_ready = en;
  assign take      = en && deq_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 16; i++) begin
        mtx[i] <= '0;
      end
    end else if (take && deq_entry.kind == w2s_pkg::CMD_LOAD) begin
      mtx[deq_entry.idx] <= deq_entry.a;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v  <= 1'b0;
      s2_v  <= 1'b0;
      s3_v  <= 1'b0;
      s4_sd <= '0;
      s5_sd <= '0;
      s6_sd <= '0;
    end else if (en) begin
      s1_v     <= take && deq_entry.kind == w2s_pkg::CMD_PROJECT;
      s2_v     <= s1_v;
      s3_v     <= s2_v;
      s4_sd.v    <= s3_v;
      s4_sd.vis  <= s3_vis;
      s4_sd.negx <= s3_nx[w2s_pkg::NUM_W-1];
      s4_sd.negy <= s3_ny[w2s_pkg::NUM_W-1];
      s4_sd.ovx  <= 1'b0;
      s4_sd.ovy  <= 1'b0;
      s5_sd    <= s4_sd;
      s6_sd.v    <= s5_sd.v;
      s6_sd.vis  <= s5_sd.vis;
      s6_sd.negx <= s5_sd.negx;
      s6_sd.negy <= s5_sd.negy;
      s6_sd.ovx  <= w2s_pkg::CMP_W'(hx) >= w2s_pkg::CMP_W'(s5_d);
      s6_sd.ovy  <= w2s_pkg::CMP_W'(hy) >= w2s_pkg::CMP_W'(s5_d);
    end
  end

  assign nx = {s5_px, {w2s_pkg::FRAC_BITS{1'b0}}};
  assign ny = {s5_py, {w2s_pkg::FRAC_BITS{1'b0}}};
  assign hx = nx[w2s_pkg::DIVN_W-1:w2s_pkg::QBITS];
  assign hy = ny[w2s_pkg::DIVN_W-1:w2s_pkg::QBITS];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        s1_p[j*3+0] <= $signed(deq_entry.a) * $signed(mtx[((j == 2) ? 3 : j)*4 + 0]);
        s1_p[j*3+1] <= $signed(deq_entry.b) * $signed(mtx[((j == 2) ? 3 : j)*4 + 1]);
        s1_p[j*3+2] <= $signed(deq_entry.c) * $signed(mtx[((j == 2) ? 3 : j)*4 + 2]);
        s1_c[j]     <= $signed(mtx[((j == 2) ? 3 : j)*4 + 3]);
      end
      s2_cx <= w2s_pkg::flr_ext(s1_p[0]) + w2s_pkg::flr_ext(s1_p[1])
             + w2s_pkg::flr_ext(s1_p[2]) + w2s_pkg::CLIP_W'(s1_c[0]);
      s2_cy <= w2s_pkg::flr_ext(s1_p[3]) + w2s_pkg::flr_ext(s1_p[4])
             + w2s_pkg::flr_ext(s1_p[5]) + w2s_pkg::CLIP_W'(s1_c[1]);
      s2_cw <= w2s_pkg::flr_ext(s1_p[6]) + w2s_pkg::flr_ext(s1_p[7])
             + w2s_pkg::flr_ext(s1_p[8]) + w2s_pkg::CLIP_W'(s1_c[2]);
      s3_nx  <= w2s_pkg::NUM_W'(s2_cw) + w2s_pkg::NUM_W'(s2_cx);
      s3_ny  <= w2s_pkg::NUM_W'(s2_cw) - w2s_pkg::NUM_W'(s2_cy);
      s3_cw  <= s2_cw;
      s3_vis <= s2_cw >= w2s_pkg::CLIP_W'(w2s_pkg::W_MIN);
      s4_mx  <= s3_nx[w2s_pkg::NUM_W-1] ? w2s_pkg::NUM_W'(-s3_nx) : s3_nx;
      s4_my  <= s3_ny[w2s_pkg::NUM_W-1] ? w2s_pkg::NUM_W'(-s3_ny) : s3_ny;
      s4_d   <= {s3_cw, 1'b0};
      s5_px  <= w2s_pkg::SCL_W'(s4_mx) * w2s_pkg::SCL_W'(screen_width);
      s5_py  <= w2s_pkg::SCL_W'(s4_my) * w2s_pkg::SCL_W'(screen_height);
      s5_d   <= s4_d;
      s6_rx  <= w2s_pkg::NUM_W'(hx);
      s6_ry  <= w2s_pkg::NUM_W'(hy);
      s6_lx  <= nx[w2s_pkg::QBITS-1:0];
      s6_ly  <= ny[w2s_pkg::QBITS-1:0];
      s6_d   <= s5_d;
    end
  end

  w2s_div u_div_x (
    .clk  (clk),
    .en   (en),
    .rem0 (s6_rx),
    .low0 (s6_lx),
    .d    (s6_d),
    .q    (qx)
  );

  w2s_div u_div_y (
    .clk  (clk),
    .en   (en),
    .rem0 (s6_ry),
    .low0 (s6_ly),
    .d    (s6_d),
    .q    (qy)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < w2s_pkg::QBITS; k++) begin
        sd[k] <= '0;
      end
    end else if (en) begin
      sd[0] <= s6_sd;
      for (int k = 1; k < w2s_pkg::QBITS; k++) begin
        sd[k] <= sd[k-1];
      end
    end
  end

  assign last = sd[w2s_pkg::QBITS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= last.v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      visible  <= last.vis;
      screen_x <= last.vis ? w2s_pkg::sat(qx, last.negx, last.ovx) : '0;
      screen_y <= last.vis ? w2s_pkg::sat(qy, last.negy, last.ovy) : '0;
    end
  end

  `W2S_ASSERT_NOW(a_hidden_zero, clk, rst, !(out_valid && !visible) || (screen_x == '0 && screen_y == '0))
  `W2S_ASSERT_NOW(a_divisor_floor, clk, rst, !(s4_sd.v && s4_sd.vis) || s4_d >= w2s_pkg::NUM_W'(2 * w2s_pkg::W_MIN))
  `W2S_ASSERT_NEXT(a_stall_hold, clk, rst, !en, $stable(s1_v) && $stable(s6_sd.v))

endmodule

[tb/tb_world_to_screen_projection_checker.sv]
// Scoreboard for the projection core: tracks matrix and viewport, predicts and compares results
module tb_world_to_screen_projection_checker
  import w2s_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic              command,
  input  logic [IDX_W-1:0]  coef_index,
  input  logic [DATA_W-1:0] coef_value,
  input  logic [DATA_W-1:0] point_x,
  input  logic [DATA_W-1:0] point_y,
  input  logic [DATA_W-1:0] point_z,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic              visible,
  input  logic [DATA_W-1:0] screen_x,
  input  logic [DATA_W-1:0] screen_y,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  input  logic              pready,
  output int                fail_count,
  output int                pending,
  output int                results_seen,
  output int                visible_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic              vis;
    logic [DATA_W-1:0] sx;
    logic [DATA_W-1:0] sy;
  } pixel_t;

  longint            view_matrix[16];
  logic [SIZE_W-1:0] width_px;
  logic [SIZE_W-1:0] height_px;
  pixel_t            pixel_queue[$];

  function automatic longint clip_sum(int row, longint x, longint y, longint z);
    longint s;
    s = ((x * view_matrix[row*4]) >>> FRAC_BITS) + ((y * view_matrix[row*4+1]) >>> FRAC_BITS)
      + ((z * view_matrix[row*4+2]) >>> FRAC_BITS) + view_matrix[row*4+3];
    return s;
  endfunction

  function automatic logic [DATA_W-1:0] scale_to_pixels(longint unsigned size, longint num,
                                                        longint w);
    logic [127:0]    prod;
    logic [127:0]    q;
    logic            neg;
    longint unsigned mag;
    neg  = num < 0;
    mag  = neg ? longint'(-num) : longint'(num);
    prod = 128'(mag) * 128'(size << FRAC_BITS);
    q    = prod / 128'(2 * w);
    if (neg) begin
      if (q > 128'h8000_0000) q = 128'h8000_0000;
      return 32'd0 - q[31:0];
    end
    if (q > 128'h7FFF_FFFF) q = 128'h7FFF_FFFF;
    return q[31:0];
  endfunction

  function automatic pixel_t project_point(logic [DATA_W-1:0] px, logic [DATA_W-1:0] py,
                                           logic [DATA_W-1:0] pz);
    pixel_t r;
    longint x, y, z, cx, cy, cw;
    x  = longint'($signed(px));
    y  = longint'($signed(py));
    z  = longint'($signed(pz));
    cx = clip_sum(0, x, y, z);
    cy = clip_sum(1, x, y, z);
    cw = clip_sum(3, x, y, z);
    r  = '{1'b0, '0, '0};
    if (cw >= W_MIN) begin
      r.vis = 1'b1;
      r.sx  = scale_to_pixels(width_px, cw + cx, cw);
      r.sy  = scale_to_pixels(height_px, cw - cy, cw);
    end
    return r;
  endfunction

  assign pending = pixel_queue.size();

  always @(posedge clk) begin
    pixel_t e;
    if (rst) begin
      foreach (view_matrix[i]) view_matrix[i] = 0;
      width_px  = WIDTH_RESET;
      height_px = HEIGHT_RESET;
      pixel_queue.delete();
      fail_count   = 0;
      results_seen = 0;
      visible_seen = 0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (visible) visible_seen++;
        if (pixel_queue.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result vis=%b x=%h y=%h", $time, visible, screen_x,
                   screen_y);
        end else begin
          e = pixel_queue.pop_front();
          if (e.vis !== visible) begin
            fail_count++;
            $display("%0t: visible expected %b actual %b", $time, e.vis, visible);
          end
          if (e.sx !== screen_x) begin
            fail_count++;
            $display("%0t: screen_x expected %h actual %h", $time, e.sx, screen_x);
          end
          if (e.sy !== screen_y) begin
            fail_count++;
            $display("%0t: screen_y expected %h actual %h", $time, e.sy, screen_y);
          end
        end
      end
      if (in_valid && in_ready) begin
        if (cmd_t'(command) == CMD_LOAD) begin
          view_matrix[coef_index] = longint'($signed(coef_value));
        end else begin
          pixel_queue.push_back(project_point(point_x, point_y, point_z));
        end
      end
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_WIDTH) width_px = pwdata[SIZE_W-1:0];
        else height_px = pwdata[SIZE_W-1:0];
      end
    end
  end
endmodule

[tb/tb_world_to_screen_projection_core.sv]
// Testbench top for the projection core: stimulus, register writes and verdict
module tb_world_to_screen_projection_core;
  import w2s_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_ready;
  logic              command;
  logic [IDX_W-1:0]  coef_index;
  logic [DATA_W-1:0] coef_value;
  logic [DATA_W-1:0] point_x;
  logic [DATA_W-1:0] point_y;
  logic [DATA_W-1:0] point_z;
  logic              out_valid;
  logic              out_ready;
  logic              visible;
  logic [DATA_W-1:0] screen_x;
  logic [DATA_W-1:0] screen_y;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  int fail_count;
  int pending;
  int results_seen;
  int visible_seen;
  int requests_sent;
  int loads_sent;
  int settings_used;
  bit hold_req;
  bit idle_on;

  localparam logic [DATA_W-1:0] ONE = 32'h0001_0000;

  world_to_screen_projection_core uut (.*);

  tb_world_to_screen_projection_checker chk (.*);

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  initial begin
    #20ms;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic int gap_len();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [DATA_W-1:0] pick_value(int spread);
    int r;
    r = $urandom_range(0, 99);
    if (r < 6) return 32'h7FFF_FFFF;
    if (r < 12) return 32'h8000_0000;
    if (r < 30) return $urandom();
    return $urandom_range(0, 2 * spread) - spread;
  endfunction

  task automatic send(cmd_t cmd, logic [IDX_W-1:0] idx, logic [DATA_W-1:0] cv,
                      logic [DATA_W-1:0] x, logic [DATA_W-1:0] y, logic [DATA_W-1:0] z,
                      int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    command    <= cmd;
    coef_index <= idx;
    coef_value <= cv;
    point_x    <= x;
    point_y    <= y;
    point_z    <= z;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
    requests_sent++;
    if (cmd == CMD_LOAD) loads_sent++;
  endtask

  task automatic load(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] cv);
    send(CMD_LOAD, idx, cv, $urandom(), $urandom(), $urandom(), gap_len());
  endtask

  task automatic project(logic [DATA_W-1:0] x, logic [DATA_W-1:0] y, logic [DATA_W-1:0] z);
    send(CMD_PROJECT, IDX_W'($urandom()), $urandom(), x, y, z, gap_len());
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic reg_write(logic reg_sel, logic [31:0] value);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {reg_sel, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_camera();
    logic [DATA_W-1:0] s;
    s = $urandom_range(1, 4) <<< 15;
    for (int i = 0; i < 16; i++) begin
      if (i == 0 || i == 5 || i == 14) load(IDX_W'(i), s + $urandom_range(0, 4095));
      else if (i == 3 || i == 7 || i == 11 || i == 15) load(IDX_W'(i), pick_value(1 << 17));
      else load(IDX_W'(i), $urandom_range(0, 1 << 14) - (1 << 13));
    end
  endtask

  task automatic random_phase(int count, bit with_hold);
    for (int n = 0; n < count; n++) begin
      if (n % 50 == 0) idle_on = ($urandom_range(0, 3) != 0);
      if (n == count / 3 && with_hold) begin
        hold_req = 1'b1;
        idle_on  = 1'b0;
        for (int k = 0; k < 60; k++) project(pick_value(1 << 20), pick_value(1 << 20), ONE);
      end
      if (n == count / 2) drain();
      if ($urandom_range(0, 99) < 3) load_camera();
      else if ($urandom_range(0, 99) < 5) load(IDX_W'($urandom()), pick_value(1 << 18));
      else project(pick_value(1 << 21), pick_value(1 << 21),
                   $urandom_range(0, 9) < 7 ? $urandom_range(0, 1 << 22) : pick_value(1 << 21));
    end
  endtask

  initial begin
    int n;
    out_ready = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        n = gap_len();
        if (n > 0) begin
          out_ready <= 1'b0;
          repeat (n) @(posedge clk);
        end
        out_ready <= 1'b1;
        repeat ($urandom_range(0, 8)) @(posedge clk);
      end
    end
  end

  initial begin
    logic [SIZE_W-1:0] sizes[8];
    rst        = 1'b1;
    in_valid   = 1'b0;
    command    = CMD_LOAD;
    coef_index = '0;
    coef_value = '0;
    point_x    = '0;
    point_y    = '0;
    point_z    = '0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    hold_req   = 1'b0;
    idle_on    = 1'b1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    project(ONE, ONE, ONE);
    load(IDX_W'(0), ONE);
    load(IDX_W'(5), ONE);
    load(IDX_W'(14), ONE);
    project(ONE >> 1, ONE >> 2, ONE);
    project(ONE, ONE, 32'd6553);
    project(ONE, ONE, 32'd6554);
    project(ONE, ONE, '0);
    project(ONE, ONE, 32'hFFFF_0000);
    project(32'h7FFF_FFFF, 32'h8000_0000, 32'd6554);
    project(32'h8000_0000, 32'h7FFF_FFFF, 32'd6554);
    project(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    load(IDX_W'(15), 32'h7FFF_FFFF);
    load(IDX_W'(3), 32'h8000_0000);
    load(IDX_W'(7), 32'h7FFF_FFFF);
    project(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    project('0, '0, '0);
    load(IDX_W'(12), 32'h8000_0000);
    load(IDX_W'(13), 32'hFFFF_FFFF);
    project(32'h8000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
    project(32'hFFFF_FFFF, 32'h8000_0000, 32'h8000_0000);
    drain();

    sizes = '{14'd1, 14'd8192, 14'd0, 14'h3FFF, 14'd1920, 14'd640, 14'd1080, 14'd4096};
    for (int p = 0; p < 5; p++) begin
      reg_write(REG_WIDTH, p < 4 ? {18'h3FFFF, sizes[p * 2]} : 32'(14'($urandom())));
      reg_write(REG_HEIGHT, p < 4 ? {18'h0, sizes[p * 2 + 1]} : $urandom());
      settings_used++;
      load_camera();
      random_phase(130, p == 1);
      drain();
    end

    $display("Covered %0d requests (%0d loads) over %0d viewport settings;", requests_sent,
             loads_sent, settings_used);
    $display("%0d results checked, %0d visible.", results_seen, visible_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
